### src/pct_pkg.sv
// ---------------------------------------------------------------------------
// Package for the particle collision time core
// Widths, item types, register indexes and reset values shared by the core.
// ---------------------------------------------------------------------------
package pct_pkg;

	localparam int DIFF_W   = 33;
	localparam int PROD_W   = 66;
	localparam int XV_W     = 68;
	localparam int VV_W     = 66;
	localparam int XX_W     = 66;
	localparam int D_W      = 69;
	localparam int NEGXV_W  = 67;
	localparam int BIG_W    = 134;
	localparam int RAD_W    = 136;

	localparam int SQ_OP_W  = 162;
	localparam int SQ_RT_W  = 81;
	localparam int SQ_RM_W  = 83;

	localparam int Q_W      = 32;
	localparam int PN_W     = 83;
	localparam int PD_W     = VV_W;
	localparam int WN_W     = 49;
	localparam int WD_W     = 32;

	localparam int FRONT_LAT = 6;
	localparam int PIPE_LAT  = FRONT_LAT + SQ_RT_W + 2 + Q_W + 1;

	localparam int REG_W = 31;
	localparam logic [REG_W-1:0] RADIUS_RST = 31'd65536;
	localparam logic [REG_W-1:0] BOX_RST    = 31'd6553600;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_BOX_X  = 2'd1,
		REG_BOX_Y  = 2'd2,
		REG_BOX_Z  = 2'd3
	} reg_idx_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] a_pos_x;
		logic signed [31:0] a_pos_y;
		logic signed [31:0] a_pos_z;
		logic signed [31:0] a_vel_x;
		logic signed [31:0] a_vel_y;
		logic signed [31:0] a_vel_z;
		logic signed [31:0] b_pos_x;
		logic signed [31:0] b_pos_y;
		logic signed [31:0] b_pos_z;
		logic signed [31:0] b_vel_x;
		logic signed [31:0] b_vel_y;
		logic signed [31:0] b_vel_z;
	} in_item_t;

	typedef struct packed {
		logic        pair_hit;
		logic [31:0] pair_time;
		logic        wall_hit;
		logic [31:0] wall_time;
		logic [1:0]  wall_axis;
	} out_item_t;

	typedef struct packed {
		logic [2:0]            hit;
		logic [2:0][WN_W-1:0]  num;
		logic [2:0][WD_W-1:0]  den;
	} wall_t;

	typedef struct packed {
		logic               go;
		logic [NEGXV_W-1:0] negxv;
		logic [VV_W-1:0]    vv;
	} pair_t;

	typedef struct packed {
		pair_t pair;
		wall_t wall;
	} side_t;

	typedef struct packed {
		logic hit;
		logic sat;
	} flag_t;

endpackage

### src/pct_stream_if.sv
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of the given type.
// ---------------------------------------------------------------------------
interface pct_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/pct_front.sv
// ---------------------------------------------------------------------------
// Front end
// Differences, dot products, discriminant and wall operands in six stages.
// ---------------------------------------------------------------------------
module pct_front
	import pct_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  in_item_t            item,
	input  logic [REG_W-1:0]    radius,
	input  logic [REG_W-1:0]    box [3],
	output logic [SQ_OP_W-1:0]  sq_op,
	output side_t               side
);

	logic signed [31:0] apos [3];
	logic signed [31:0] avel [3];
	logic signed [31:0] bpos [3];
	logic signed [31:0] bvel [3];

	assign apos = '{item.a_pos_x, item.a_pos_y, item.a_pos_z};
	assign avel = '{item.a_vel_x, item.a_vel_y, item.a_vel_z};
	assign bpos = '{item.b_pos_x, item.b_pos_y, item.b_pos_z};
	assign bvel = '{item.b_vel_x, item.b_vel_y, item.b_vel_z};

	logic signed [DIFF_W-1:0] dx_s1 [3];
	logic signed [DIFF_W-1:0] dv_s1 [3];
	logic [31:0]              rr_s1;
	wall_t                    wall_n;
	wall_t                    wall_s1;

	always_comb begin
		logic signed [34:0] d;
		for (int i = 0; i < 3; i++) begin
			if (avel[i][31]) begin
				d = {{3{apos[i][31]}}, apos[i]} - $signed({4'b0, radius});
			end else begin
				d = $signed({4'b0, box[i]}) - $signed({4'b0, radius})
					- {{3{apos[i][31]}}, apos[i]};
			end
			wall_n.hit[i] = (avel[i] != '0);
			wall_n.num[i] = (!d[34] && d != '0) ? {d[32:0], 16'b0} : '0;
			wall_n.den[i] = avel[i][31] ? (~avel[i] + 32'd1) : avel[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dx_s1[i] <= {apos[i][31], apos[i]} - {bpos[i][31], bpos[i]};
				dv_s1[i] <= {avel[i][31], avel[i]} - {bvel[i][31], bvel[i]};
			end
			rr_s1   <= {radius, 1'b0};
			wall_s1 <= wall_n;
		end
	end

	logic signed [PROD_W-1:0] pxv_s2 [3];
	logic signed [PROD_W-1:0] pvv_s2 [3];
	logic signed [PROD_W-1:0] pxx_s2 [3];
	logic [63:0]              rr2_s2;
	wall_t                    wall_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pxv_s2[i] <= dx_s1[i] * dv_s1[i];
				pvv_s2[i] <= dv_s1[i] * dv_s1[i];
				pxx_s2[i] <= dx_s1[i] * dx_s1[i];
			end
			rr2_s2  <= rr_s1 * rr_s1;
			wall_s2 <= wall_s1;
		end
	end

	logic signed [XV_W-1:0] xv_s3;
	logic [VV_W-1:0]        vv_s3;
	logic signed [D_W-1:0]  d_s3;
	wall_t                  wall_s3;
	logic [XX_W-1:0]        xx_sum;

	assign xx_sum = XX_W'(pxx_s2[0]) + XX_W'(pxx_s2[1]) + XX_W'(pxx_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			xv_s3   <= XV_W'(pxv_s2[0]) + XV_W'(pxv_s2[1]) + XV_W'(pxv_s2[2]);
			vv_s3   <= VV_W'(pvv_s2[0]) + VV_W'(pvv_s2[1]) + VV_W'(pvv_s2[2]);
			d_s3    <= $signed({3'b0, xx_sum}) - $signed({5'b0, rr2_s2});
			wall_s3 <= wall_s2;
		end
	end

	logic [NEGXV_W-1:0] axv;
	logic [D_W-2:0]     ad;
	logic [XV_W-1:0]    xv_neg;
	logic [D_W-1:0]     d_neg;

	assign xv_neg = -xv_s3;
	assign d_neg  = -d_s3;
	assign axv    = xv_s3[XV_W-1] ? xv_neg[NEGXV_W-1:0] : xv_s3[NEGXV_W-1:0];
	assign ad     = d_s3[D_W-1] ? d_neg[D_W-2:0] : d_s3[D_W-2:0];

	logic [67:0]        xll_s4;
	logic [66:0]        xlh_s4;
	logic [65:0]        xhh_s4;
	logic [67:0]        vdll_s4;
	logic [67:0]        vdlh_s4;
	logic [65:0]        vdhl_s4;
	logic [65:0]        vdhh_s4;
	logic               xneg_s4;
	logic               dneg_s4;
	logic [NEGXV_W-1:0] axv_s4;
	logic [VV_W-1:0]    vv_s4;
	wall_t              wall_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xll_s4  <= axv[33:0] * axv[33:0];
			xlh_s4  <= axv[33:0] * axv[66:34];
			xhh_s4  <= axv[66:34] * axv[66:34];
			vdll_s4 <= vv_s3[33:0] * ad[33:0];
			vdlh_s4 <= vv_s3[33:0] * ad[67:34];
			vdhl_s4 <= vv_s3[65:34] * ad[33:0];
			vdhh_s4 <= vv_s3[65:34] * ad[67:34];
			xneg_s4 <= xv_s3[XV_W-1];
			dneg_s4 <= d_s3[D_W-1];
			axv_s4  <= axv;
			vv_s4   <= vv_s3;
			wall_s4 <= wall_s3;
		end
	end

	logic [BIG_W-1:0]   xv2_s5;
	logic [BIG_W-1:0]   vd_s5;
	logic               xneg_s5;
	logic               dneg_s5;
	logic [NEGXV_W-1:0] axv_s5;
	logic [VV_W-1:0]    vv_s5;
	wall_t              wall_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			xv2_s5  <= BIG_W'(xll_s4) + (BIG_W'(xlh_s4) << 35) + (BIG_W'(xhh_s4) << 68);
			vd_s5   <= BIG_W'(vdll_s4) + ((BIG_W'(vdlh_s4) + BIG_W'(vdhl_s4)) << 34)
				+ (BIG_W'(vdhh_s4) << 68);
			xneg_s5 <= xneg_s4;
			dneg_s5 <= dneg_s4;
			axv_s5  <= axv_s4;
			vv_s5   <= vv_s4;
			wall_s5 <= wall_s4;
		end
	end

	logic [RAD_W-1:0] rad;
	logic             go;

	assign rad = dneg_s5 ? ({2'b0, xv2_s5} + {2'b0, vd_s5})
		: ({2'b0, xv2_s5} - {2'b0, vd_s5});
	assign go  = xneg_s5 && (vv_s5 != '0) && !rad[RAD_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_op           <= go ? {rad[129:0], 32'b0} : '0;
			side.pair.go    <= go;
			side.pair.negxv <= axv_s5;
			side.pair.vv    <= vv_s5;
			side.wall       <= wall_s5;
		end
	end

endmodule

### src/pct_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One digit of the restoring square root; hands the operand on to the next cell.
// ---------------------------------------------------------------------------
module pct_sqrt_cell
	import pct_pkg::*;
#(
	parameter int OW = SQ_OP_W,
	parameter int RW = SQ_RT_W,
	parameter int MW = SQ_RM_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [OW-1:0] op_i,
	input  logic [MW-1:0] rem_i,
	input  logic [RW-1:0] root_i,
	input  side_t         side_i,
	output logic [OW-1:0] op_o,
	output logic [MW-1:0] rem_o,
	output logic [RW-1:0] root_o,
	output side_t         side_o
);

	logic [MW+1:0] r2;
	logic [MW+1:0] trial;
	logic [MW+1:0] diff;
	logic          take;

	assign r2    = {rem_i, op_i[OW-1:OW-2]};
	assign trial = {{(MW-RW){1'b0}}, root_i, 2'b01};
	assign diff  = r2 - trial;
	assign take  = (r2 >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			op_o   <= {op_i[OW-3:0], 2'b00};
			rem_o  <= take ? diff[MW-1:0] : r2[MW-1:0];
			root_o <= {root_i[RW-2:0], take};
			side_o <= side_i;
		end
	end

endmodule

### src/pct_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division at a fixed bit position.
// ---------------------------------------------------------------------------
module pct_div_cell
	import pct_pkg::*;
#(
	parameter int NW  = PN_W,
	parameter int DW  = PD_W,
	parameter int BIT = Q_W - 1
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  rem_i,
	input  logic [DW-1:0]  den_i,
	input  logic [Q_W-1:0] q_i,
	input  flag_t          flag_i,
	output logic [NW-1:0]  rem_o,
	output logic [DW-1:0]  den_o,
	output logic [Q_W-1:0] q_o,
	output flag_t          flag_o
);

	localparam int CW = ((NW - BIT) > DW) ? (NW - BIT) : DW;

	logic [CW-1:0]  hi;
	logic [CW-1:0]  dd;
	logic           take;
	logic [Q_W-1:0] q_n;

	assign hi   = CW'(rem_i >> BIT);
	assign dd   = CW'(den_i);
	assign take = (hi >= dd);

	always_comb begin
		q_n      = q_i;
		q_n[BIT] = take;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= take ? (rem_i - (NW'(den_i) << BIT)) : rem_i;
			den_o  <= den_i;
			q_o    <= q_n;
			flag_o <= flag_i;
		end
	end

endmodule

### src/particle_collision_time_core.sv
// ---------------------------------------------------------------------------
// Particle collision time core
// Pair contact time and nearest wall time of two hard spheres, one item a cycle.
// ---------------------------------------------------------------------------
// The core takes one pair of spheres every clock cycle and returns one result
// item for each, in order. The pipeline is made of the 81 square root cells of
// the contact time, followed by four chains of 32 divider cells that run the
// pair quotient and the three wall quotients side by side; six front stages
// and three post stages make up the rest. When the result register is full
// and not taken the whole pipeline holds. Configuration writes are taken at any
// time but must only be issued while no item is in flight.
module particle_collision_time_core
	import pct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	pct_stream_if.sink          req,
	pct_stream_if.source        rsp,
	input  logic                cfg_we,
	input  reg_idx_t            cfg_addr,
	input  logic [REG_W-1:0]    cfg_wdata
);

	logic [REG_W-1:0] radius_q;
	logic [REG_W-1:0] box_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			box_q    <= '{BOX_RST, BOX_RST, BOX_RST};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RADIUS: radius_q <= cfg_wdata;
				REG_BOX_X:  box_q[0] <= cfg_wdata;
				REG_BOX_Y:  box_q[1] <= cfg_wdata;
				REG_BOX_Z:  box_q[2] <= cfg_wdata;
				default:    radius_q <= radius_q;
			endcase
		end
	end

	logic                en;
	logic [PIPE_LAT:1]   vld_q;

	assign en        = !(vld_q[PIPE_LAT] && !rsp.ready);
	assign req.ready = en;
	assign rsp.valid = vld_q[PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-1:1], req.valid};
		end
	end

	logic [SQ_OP_W-1:0] sq_op   [0:SQ_RT_W];
	logic [SQ_RM_W-1:0] sq_rem  [0:SQ_RT_W];
	logic [SQ_RT_W-1:0] sq_root [0:SQ_RT_W];
	side_t              sq_side [0:SQ_RT_W];

	pct_front u_front (
		.clk    (clk),
		.en     (en),
		.item   (req.data),
		.radius (radius_q),
		.box    (box_q),
		.sq_op  (sq_op[0]),
		.side   (sq_side[0])
	);

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ_RT_W; k++) begin : g_sqrt
		pct_sqrt_cell #(
			.OW (SQ_OP_W),
			.RW (SQ_RT_W),
			.MW (SQ_RM_W)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.op_i   (sq_op[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.op_o   (sq_op[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	logic [PN_W:0] n_full;
	side_t         side_r;

	assign side_r = sq_side[SQ_RT_W];
	assign n_full = {1'b0, side_r.pair.negxv, 16'b0} - {3'b0, sq_root[SQ_RT_W]};

	logic [PN_W-1:0] pnum_s1;
	logic            phit_s1;
	logic [VV_W-1:0] vv_s1;
	wall_t           wall_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			phit_s1 <= side_r.pair.go && !n_full[PN_W] && (n_full != '0);
			pnum_s1 <= (side_r.pair.go && !n_full[PN_W]) ? n_full[PN_W-1:0] : '0;
			vv_s1   <= side_r.pair.vv;
			wall_s1 <= side_r.wall;
		end
	end

	logic [PN_W-1:0] p_rem  [0:Q_W];
	logic [PD_W-1:0] p_den  [0:Q_W];
	logic [Q_W-1:0]  p_q    [0:Q_W];
	flag_t           p_flag [0:Q_W];

	logic [WN_W-1:0] w_rem  [3][0:Q_W];
	logic [WD_W-1:0] w_den  [3][0:Q_W];
	logic [Q_W-1:0]  w_q    [3][0:Q_W];
	flag_t           w_flag [3][0:Q_W];

	logic [PN_W-1:0] pnum_s2;
	logic [PD_W-1:0] pden_s2;
	flag_t           pflag_s2;
	logic [WN_W-1:0] wnum_s2  [3];
	logic [WD_W-1:0] wden_s2  [3];
	flag_t           wflag_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			pnum_s2      <= pnum_s1;
			pden_s2      <= vv_s1;
			pflag_s2.hit <= phit_s1;
			pflag_s2.sat <= (PD_W'(pnum_s1[PN_W-1:Q_W]) >= vv_s1);
			for (int i = 0; i < 3; i++) begin
				wnum_s2[i]      <= wall_s1.num[i];
				wden_s2[i]      <= wall_s1.den[i];
				wflag_s2[i].hit <= wall_s1.hit[i];
				wflag_s2[i].sat <= (WD_W'(wall_s1.num[i][WN_W-1:Q_W]) >= wall_s1.den[i]);
			end
		end
	end

	assign p_rem[0]  = pnum_s2;
	assign p_den[0]  = pden_s2;
	assign p_q[0]    = '0;
	assign p_flag[0] = pflag_s2;

	for (genvar j = 0; j < Q_W; j++) begin : g_pdiv
		pct_div_cell #(
			.NW  (PN_W),
			.DW  (PD_W),
			.BIT (Q_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (p_rem[j]),
			.den_i  (p_den[j]),
			.q_i    (p_q[j]),
			.flag_i (p_flag[j]),
			.rem_o  (p_rem[j+1]),
			.den_o  (p_den[j+1]),
			.q_o    (p_q[j+1]),
			.flag_o (p_flag[j+1])
		);
	end

	for (genvar a = 0; a < 3; a++) begin : g_wall
		assign w_rem[a][0]  = wnum_s2[a];
		assign w_den[a][0]  = wden_s2[a];
		assign w_q[a][0]    = '0;
		assign w_flag[a][0] = wflag_s2[a];

		for (genvar j = 0; j < Q_W; j++) begin : g_wdiv
			pct_div_cell #(
				.NW  (WN_W),
				.DW  (WD_W),
				.BIT (Q_W - 1 - j)
			) u_cell (
				.clk    (clk),
				.en     (en),
				.rem_i  (w_rem[a][j]),
				.den_i  (w_den[a][j]),
				.q_i    (w_q[a][j]),
				.flag_i (w_flag[a][j]),
				.rem_o  (w_rem[a][j+1]),
				.den_o  (w_den[a][j+1]),
				.q_o    (w_q[a][j+1]),
				.flag_o (w_flag[a][j+1])
			);
		end
	end

	localparam logic [1:0] AXIS_CODE [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

	out_item_t      res_n;
	out_item_t      res_q;
	logic [Q_W-1:0] w_t [3];

	always_comb begin
		flag_t pf;
		pf = p_flag[Q_W];
		for (int i = 0; i < 3; i++) begin
			w_t[i] = w_flag[i][Q_W].sat ? '1 : w_q[i][Q_W];
		end
		res_n.pair_hit  = pf.hit;
		res_n.pair_time = !pf.hit ? '0 : (pf.sat ? '1 : p_q[Q_W]);
		res_n.wall_hit  = 1'b0;
		res_n.wall_time = '0;
		res_n.wall_axis = AXIS_X;
		for (int i = 0; i < 3; i++) begin
			if (w_flag[i][Q_W].hit && (!res_n.wall_hit || w_t[i] < res_n.wall_time)) begin
				res_n.wall_hit  = 1'b1;
				res_n.wall_time = w_t[i];
				res_n.wall_axis = AXIS_CODE[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_n;
		end
	end

	assign rsp.data = res_q;

`ifndef NO_ASSERTIONS
	a_pair_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.pair_hit |-> rsp.data.pair_time == '0)
		else $error("pair miss with nonzero time");

	a_wall_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.wall_hit |-> rsp.data.wall_time == '0
			&& rsp.data.wall_axis == AXIS_X)
		else $error("wall miss with nonzero fields");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.wall_axis != 2'd3)
		else $error("wall axis out of range");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while pipeline held");
`endif

endmodule
